FILE: rtl/core/rbd2_pkg.sv
// Shared types and constants for the RGBA 2x2 box downsampler.
`timescale 1ns / 1ps

package rbd2_pkg;

    localparam int CH_W          = 8;
    localparam int N_CH          = 4;
    localparam int PAIR_W        = CH_W + 1;
    localparam int SUM_W         = CH_W + 2;
    localparam int ENTRY_W       = N_CH * PAIR_W;
    localparam int PIX_W         = N_CH * CH_W;
    localparam int SRC_WIDTH_W   = 13;
    localparam int SRC_HEIGHT_W  = 16;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int DEF_MAX_WIDTH = 4096;

    // Register index codes (byte address = 4 * index)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [N_CH-1:0][CH_W-1:0]   t_pixel;
    typedef logic [N_CH-1:0][PAIR_W-1:0] t_pair;

    // Frame geometry derived from the configuration registers
    typedef struct packed {
        logic                      restart;
        logic                      busy;
        logic                      w_is1;
        logic                      h_is1;
        logic [1:0]                shift;
        logic [SRC_HEIGHT_W-1:0]   last_row;
        logic [SRC_HEIGHT_W-2:0]   last_out_row;
    } t_geom;

    // Item handed from the front stage to the averaging stage
    typedef struct packed {
        t_pair      pair;
        logic       use_mem;
        logic       last;
        logic [1:0] shift;
    } t_s1;

endpackage

FILE: rtl/core/rbd2_cfg.sv
// APB configuration registers and derived frame geometry.
`timescale 1ns / 1ps

module rbd2_cfg
    import rbd2_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int CW        = $clog2(MAX_WIDTH),
    parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_geom                 o_geom,
    output logic [CW-1:0]         o_last_col,
    output logic [CW-1:0]         o_last_idx
);

    logic [SRC_WIDTH_W-1:0]  r_width;
    logic [SRC_HEIGHT_W-1:0] r_height;
    logic                    wr;
    logic [WW-1:0]           w_eff;
    logic [SRC_HEIGHT_W-1:0] h_eff;
    t_geom                   r_geom;
    t_geom                   n_geom;
    logic [CW-1:0]           r_last_col;
    logic [CW-1:0]           r_last_idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SRC_WIDTH_W'(1);
            r_height <= SRC_HEIGHT_W'(1);
        end else if (wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[SRC_WIDTH_W-1:0];
                REG_HEIGHT: r_height <= pwdata[SRC_HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    // Clamp width to 1..MAX_WIDTH, height to at least 1
    always_comb begin
        if (r_width == '0)
            w_eff = WW'(1);
        else if (32'(r_width) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(r_width);
        h_eff = (r_height == '0) ? SRC_HEIGHT_W'(1) : r_height;

        n_geom.restart      = wr;
        n_geom.busy         = wr;
        n_geom.w_is1        = (w_eff == WW'(1));
        n_geom.h_is1        = (h_eff == SRC_HEIGHT_W'(1));
        n_geom.shift        = 2'(!n_geom.w_is1) + 2'(!n_geom.h_is1);
        n_geom.last_row     = h_eff - SRC_HEIGHT_W'(1);
        n_geom.last_out_row = (SRC_HEIGHT_W-1)'((h_eff >> 1) - SRC_HEIGHT_W'(1));
    end

    // Register the derived geometry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom     <= '{restart: 1'b0, busy: 1'b0, w_is1: 1'b1, h_is1: 1'b1,
                            shift: 2'd0, last_row: '0, last_out_row: '1};
            r_last_col <= '0;
            r_last_idx <= '1;
        end else begin
            r_geom     <= n_geom;
            r_last_col <= CW'(w_eff - WW'(1));
            r_last_idx <= CW'((w_eff >> 1) - WW'(1));
        end
    end

    // Restart goes out at once; hold input off during the write and the cycle
    // after it, while the derived geometry catches up with the new registers
    always_comb begin
        o_geom         = r_geom;
        o_geom.restart = wr;
        o_geom.busy    = wr || r_geom.busy;
    end
    assign o_last_col = r_last_col;
    assign o_last_idx = r_last_idx;

endmodule

FILE: rtl/core/rbd2_line_mem.sv
// Line store of even-row horizontal pair sums with a registered read port.
`timescale 1ns / 1ps

module rbd2_line_mem
    import rbd2_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH / 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [ENTRY_W-1:0] i_wr_data,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [ENTRY_W-1:0] o_rd_data
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en)
            r_mem[i_wr_addr] <= i_wr_data;
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en)
            r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/rbd2_front.sv
// Raster tracking, horizontal pairing and line store access.
`timescale 1ns / 1ps

module rbd2_front
    import rbd2_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int CW        = $clog2(MAX_WIDTH),
    parameter int DEPTH     = MAX_WIDTH / 2,
    parameter int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_geom              i_geom,
    input  logic [CW-1:0]      i_last_col,
    input  logic [CW-1:0]      i_last_idx,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_pixel             i_pixel,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [ENTRY_W-1:0] o_wr_data,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    output logic               o_s1_valid,
    output t_s1                o_s1,
    input  logic               i_s1_take
);

    logic [CW-1:0]           r_col;
    logic [SRC_HEIGHT_W-1:0] r_row;
    t_pixel                  r_hold;
    logic                    r_s1_valid;
    t_s1                     r_s1;
    logic                    accept;
    logic                    col_wrap;
    logic                    have_pair;
    logic                    emit;
    t_pair                   pair;
    logic [AW-1:0]           idx;
    logic                    x_last;
    logic                    y_last;

    assign o_ready  = (!r_s1_valid || i_s1_take) && !i_geom.busy;
    assign accept   = i_valid && o_ready;
    assign col_wrap = (r_col == i_last_col);
    assign idx      = AW'(r_col >> 1);

    // Form the horizontal pair
    always_comb begin
        for (int i = 0; i < N_CH; i++) begin
            if (i_geom.w_is1)
                pair[i] = PAIR_W'(i_pixel[i]);
            else
                pair[i] = PAIR_W'(r_hold[i]) + PAIR_W'(i_pixel[i]);
        end
        have_pair = i_geom.w_is1 || r_col[0];
        emit      = have_pair && (i_geom.h_is1 || r_row[0]);
        x_last    = i_geom.w_is1 || ((r_col >> 1) == i_last_idx);
        y_last    = i_geom.h_is1 || (r_row[SRC_HEIGHT_W-1:1] == i_geom.last_out_row);
    end

    // Even rows store pairs, odd rows fetch them
    assign o_wr_en   = accept && have_pair && !i_geom.h_is1 && !r_row[0]
                       && (r_row != i_geom.last_row);
    assign o_wr_addr = idx;
    assign o_wr_data = pair;
    assign o_rd_en   = accept && emit && !i_geom.h_is1;
    assign o_rd_addr = idx;

    // Advance raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_geom.restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= (r_row == i_geom.last_row) ? '0 : r_row + SRC_HEIGHT_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Hold the even-column pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_geom.restart)
            r_hold <= '0;
        else if (accept && !i_geom.w_is1 && !r_col[0] && !col_wrap)
            r_hold <= i_pixel;
    end

    // Stage register toward the averaging stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s1_valid <= 1'b0;
        else if (accept)
            r_s1_valid <= emit;
        else if (i_s1_take)
            r_s1_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.pair    <= pair;
            r_s1.use_mem <= !i_geom.h_is1;
            r_s1.last    <= x_last && y_last;
            r_s1.shift   <= i_geom.shift;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

FILE: rtl/core/rbd2_back.sv
// Vertical sum, divide by pixel count, and output register.
`timescale 1ns / 1ps

module rbd2_back
    import rbd2_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s1_valid,
    input  t_s1                i_s1,
    input  logic [ENTRY_W-1:0] i_rd_data,
    output logic               o_s1_take,
    output logic               o_valid,
    input  logic               i_ready,
    output t_pixel             o_pixel,
    output logic               o_last
);

    t_pair              stored;
    logic [SUM_W-1:0]   sum;
    t_pixel             avg;
    logic               r_valid;
    t_pixel             r_pixel;
    logic               r_last;

    assign o_s1_take = i_s1_valid && (!r_valid || i_ready);
    assign stored    = i_rd_data;

    // Add the stored even-row pair and shift by log2 of the count
    always_comb begin
        sum = '0;
        for (int i = 0; i < N_CH; i++) begin
            sum    = SUM_W'(i_s1.pair[i]) + (i_s1.use_mem ? SUM_W'(stored[i]) : '0);
            avg[i] = CH_W'(sum >> i_s1.shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= 1'b0;
        else if (o_s1_take)
            r_valid <= 1'b1;
        else if (i_ready)
            r_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_take) begin
            r_pixel <= avg;
            r_last  <= i_s1.last;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_last  = r_last;

endmodule

FILE: rtl/core/rgba_box_downsample_2x2_top.sv
// Top level of the RGBA8 2x2 box downsampler.
`timescale 1ns / 1ps
//
// Source pixels enter on the s_axis channel in raster order, one transfer per
// pixel, for an image of src_width x src_height set over the APB port
// (width at 0x0, height at 0x4). Each 2x2 block yields one pixel on the
// m_axis channel: each channel is the block sum divided, truncating, by 4
// (by 2 for a one-pixel-wide or one-pixel-high image, by 1 for a single
// pixel). An odd last column or row is accepted and dropped. tlast marks the
// last output pixel of the image.
// Throughput is one source pixel per cycle unless a register write or an m_axis
// stall holds input off. The pixel completing a block and its line store read
// are registered first; the sum and divide then feed the output register.
// Pair sums of even rows live in a MAX_WIDTH/2 entry line store; odd rows read
// them back at the same column, at least one row later, so no forwarding is
// needed.
// Reset clears the raster position and empties the pipeline; any register
// write restarts the frame at row 0, column 0, and s_axis_tready stays low in
// the write's access cycle and the cycle after it. When m_axis stalls, the
// output register and, once full, the stage before it hold; s_axis_tready drops.
//
module rgba_box_downsample_2x2_top
    import rbd2_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: [7:0] in_red, [15:8] in_green, [23:16] in_blue, [31:24] in_alpha
    input  logic [PIX_W-1:0]      s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
    output logic [PIX_W-1:0]      m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_geom              geom;
    logic [CW-1:0]      last_col;
    logic [CW-1:0]      last_idx;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               s1_valid;
    t_s1                s1;
    logic               s1_take;
    t_pixel             out_pixel;

    rbd2_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_geom     (geom),
        .o_last_col (last_col),
        .o_last_idx (last_idx)
    );

    rbd2_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (geom),
        .i_last_col (last_col),
        .i_last_idx (last_idx),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_pixel    (s_axis_tdata),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .i_s1_take  (s1_take)
    );

    rbd2_line_mem #(
        .DEPTH (DEPTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rbd2_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .i_rd_data  (rd_data),
        .o_s1_take  (s1_take),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_pixel    (out_pixel),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = out_pixel;

endmodule
